### rtl/lwsc_pkg.sv
// Shared types and constants for the LRU write-back sector cache controller.
// No dependencies.
`timescale 1ns / 1ps
package lwsc_pkg;
    localparam int ENTRIES = 64;
    localparam int SLOT_W  = $clog2(ENTRIES);
    localparam int QDEPTH  = 2;

    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_FLUSH = 2'd2;
    localparam logic [1:0] REQ_RSVD  = 2'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] sector;
    } req_t;

    typedef struct packed {
        logic [5:0]  slot;
        logic        hit;
        logic        fill_needed;
        logic        writeback_needed;
        logic [31:0] writeback_sector;
        logic        last;
    } rsp_t;

    // Classified command passed from the front part to the back part.
    typedef struct packed {
        logic        flush;
        logic        write;
        logic [31:0] sector;
    } cmd_t;
endpackage

### rtl/lru_writeback_sector_cache_ctrl.sv
// Top level of the LRU write-back sector cache controller.
// Depends on lwsc_pkg, lwsc_front and lwsc_back.
`timescale 1ns / 1ps
// Tag and policy controller for a 64-slot fully associative write-back
// sector cache with true LRU replacement. In the back part a read or write
// item is taken with the parallel tag compare and victim pick, then the rank,
// valid and dirty update and the result follow once the output register is
// free. A flush item is taken, walks the slots one per cycle unless a dirty
// slot waits on a stalled output, and then closes; it
// emits one writeback item per valid dirty slot, or a single empty item with
// last set. Reserved request codes are dropped at the input. A two-entry
// queue sits between the front and back, and the result sits in an output
// register.
module lru_writeback_sector_cache_ctrl
    import lwsc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  req_t in_data,
    output logic out_valid,
    input  logic out_stall,
    output rsp_t out_data
);
    logic cmd_valid;
    logic cmd_take;
    cmd_t cmd_data;

    lwsc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd_data  (cmd_data)
    );

    lwsc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd_data  (cmd_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );
endmodule

### rtl/lwsc_front.sv
// Front part: accepts request items, drops reserved codes, and queues
// classified commands. Depends on lwsc_pkg.
`timescale 1ns / 1ps
module lwsc_front
    import lwsc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  req_t in_data,
    output logic cmd_valid,
    input  logic cmd_take,
    output cmd_t cmd_data
);
    localparam int PW = $clog2(QDEPTH);

    cmd_t             q_mem [QDEPTH];
    logic [PW-1:0]    wp_reg, rp_reg;
    logic [PW:0]      cnt_reg;
    logic             push;
    logic             pop;

    assign in_stall  = (cnt_reg == (PW+1)'(QDEPTH));
    assign push      = in_valid && !in_stall && (in_data.req_type != REQ_RSVD);
    assign cmd_valid = (cnt_reg != '0);
    assign pop       = cmd_valid && cmd_take;
    assign cmd_data  = q_mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wp_reg].flush  <= (in_data.req_type == REQ_FLUSH);
            q_mem[wp_reg].write  <= (in_data.req_type == REQ_WRITE);
            q_mem[wp_reg].sector <= in_data.sector;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= PW'((32'(wp_reg) + 1) % QDEPTH);
            if (pop)
                rp_reg <= PW'((32'(rp_reg) + 1) % QDEPTH);
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end
endmodule

### rtl/lwsc_back.sv
// Back part: tag lookup, LRU victim search, rank update and flush walk.
// Drives a one-entry output register. Depends on lwsc_pkg.
`timescale 1ns / 1ps
module lwsc_back
    import lwsc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_take,
    input  cmd_t cmd_data,
    output logic out_valid,
    input  logic out_stall,
    output rsp_t out_data
);
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ACC   = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [31:0]       tag_reg   [ENTRIES];
    logic [ENTRIES-1:0] valid_reg, dirty_reg;
    logic [SLOT_W-1:0] rank_reg  [ENTRIES];

    logic [1:0]        st_reg;
    cmd_t              cmd_reg;
    logic              hit_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W:0]   walk_reg;
    logic              found_reg;
    logic              ov_reg;
    rsp_t              od_reg;

    logic              ofree;
    logic              mhit;
    logic [SLOT_W-1:0] mslot, vslot;
    logic [SLOT_W-1:0] sel;
    logic [ENTRIES-1:0] dmask;
    logic              more;
    logic              emit;

    assign out_valid = ov_reg;
    assign out_data  = od_reg;
    assign ofree     = !ov_reg || !out_stall;
    assign cmd_take  = (st_reg == ST_IDLE);

    // Parallel tag compare; priority to the lowest match.
    always_comb
    begin
        mhit  = 1'b0;
        mslot = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && tag_reg[i] == cmd_data.sector)
            begin
                mhit  = 1'b1;
                mslot = SLOT_W'(i);
            end
        end
    end

    // The victim is the slot whose rank is the oldest.
    always_comb
    begin
        vslot = '0;
        for (int i = 0; i < ENTRIES; i++)
            if (rank_reg[i] == SLOT_W'(ENTRIES - 1))
                vslot = SLOT_W'(i);
    end

    // Dirty slots still ahead of the flush walk.
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
            dmask[i] = valid_reg[i] && dirty_reg[i] && ((SLOT_W+1)'(i) >= walk_reg);
    end

    // Dirty slots beyond the current one, for the last flag.
    always_comb
    begin
        more = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
            if ((SLOT_W+1)'(i) > walk_reg && valid_reg[i] && dirty_reg[i])
                more = 1'b1;
    end

    // A result item is loaded into the output register this cycle.
    always_comb
    begin
        emit = 1'b0;
        case (st_reg)
            ST_ACC:
                emit = ofree;
            ST_FLUSH:
            begin
                if (walk_reg == (SLOT_W+1)'(ENTRIES))
                    emit = ofree && !found_reg;
                else
                    emit = ofree && dmask[walk_reg[SLOT_W-1:0]];
            end
            default:
                emit = 1'b0;
        endcase
    end

    assign sel = slot_reg;

    always_ff @(posedge clk)
    begin
        if (st_reg == ST_ACC && ofree && !hit_reg)
            tag_reg[sel] <= cmd_reg.sector;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= ST_IDLE;
            valid_reg <= '0;
            dirty_reg <= '0;
            ov_reg    <= 1'b0;
            walk_reg  <= '0;
            found_reg <= 1'b0;
            for (int i = 0; i < ENTRIES; i++)
                rank_reg[i] <= SLOT_W'(i);
        end
        else
        begin
            ov_reg <= emit || (ov_reg && out_stall);
            case (st_reg)
                ST_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cmd_reg   <= cmd_data;
                        hit_reg   <= mhit;
                        slot_reg  <= mhit ? mslot : vslot;
                        walk_reg  <= '0;
                        found_reg <= 1'b0;
                        st_reg    <= cmd_data.flush ? ST_FLUSH : ST_ACC;
                    end
                end
                ST_ACC:
                begin
                    if (ofree)
                    begin
                        od_reg.slot              <= 6'(sel);
                        od_reg.hit               <= hit_reg;
                        od_reg.fill_needed       <= !hit_reg;
                        od_reg.writeback_needed  <= !hit_reg && valid_reg[sel] && dirty_reg[sel];
                        od_reg.writeback_sector  <= (!hit_reg && valid_reg[sel] && dirty_reg[sel])
                                                    ? tag_reg[sel] : 32'd0;
                        od_reg.last              <= 1'b1;
                        valid_reg[sel]           <= 1'b1;
                        dirty_reg[sel]           <= cmd_reg.write || (hit_reg && dirty_reg[sel]);
                        for (int i = 0; i < ENTRIES; i++)
                            if (rank_reg[i] < rank_reg[sel])
                                rank_reg[i] <= rank_reg[i] + SLOT_W'(1);
                        rank_reg[sel]            <= '0;
                        st_reg                   <= ST_IDLE;
                    end
                end
                ST_FLUSH:
                begin
                    // One slot examined per cycle, unless a dirty slot waits on a stalled output.
                    if (walk_reg == (SLOT_W+1)'(ENTRIES))
                    begin
                        if (found_reg)
                            st_reg <= ST_IDLE;
                        else if (ofree)
                        begin
                            od_reg <= '{slot: '0, hit: 1'b0, fill_needed: 1'b0,
                                        writeback_needed: 1'b0,
                                        writeback_sector: 32'd0, last: 1'b1};
                            st_reg <= ST_IDLE;
                        end
                    end
                    else if (!dmask[walk_reg[SLOT_W-1:0]])
                        walk_reg <= walk_reg + (SLOT_W+1)'(1);
                    else if (ofree)
                    begin
                        od_reg <= '{slot: 6'(walk_reg[SLOT_W-1:0]), hit: 1'b0,
                                    fill_needed: 1'b0, writeback_needed: 1'b1,
                                    writeback_sector: tag_reg[walk_reg[SLOT_W-1:0]],
                                    last: !more};
                        found_reg <= 1'b1;
                        walk_reg  <= walk_reg + (SLOT_W+1)'(1);
                    end
                end
                default:
                    st_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

### verif/lwsc_checker.sv
// Checker for the LRU write-back sector cache controller: watches both channels,
// predicts each result from its own tag, valid, dirty and rank copy. Depends on lwsc_pkg.
`timescale 1ns / 1ps
module lwsc_checker
    import lwsc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic in_stall,
    input  req_t in_data,
    input  logic out_valid,
    input  logic out_stall,
    input  rsp_t out_data,
    output int   fail_count,
    output int   pending
);
    logic [31:0] tags [ENTRIES];
    logic        vld  [ENTRIES];
    logic        drt  [ENTRIES];
    int          rank [ENTRIES];
    rsp_t        want_q[$];

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        fail_count++;
    endtask

    function automatic rsp_t mk(int s, bit h, bit f, bit w, logic [31:0] ws, bit l);
        rsp_t r;
        r.slot = s[5:0];
        r.hit = h;
        r.fill_needed = f;
        r.writeback_needed = w;
        r.writeback_sector = ws;
        r.last = l;
        return r;
    endfunction

    task automatic predict_access(input req_t q);
        int s;
        int r0;
        bit h;
        bit w;
        logic [31:0] ws;
        s = -1;
        h = 0;
        w = 0;
        ws = '0;
        if (q.req_type == REQ_FLUSH)
        begin
            int lastd;
            lastd = -1;
            for (int i = 0; i < ENTRIES; i++)
                if (vld[i] && drt[i]) lastd = i;
            if (lastd < 0)
                want_q.push_back(mk(0, 0, 0, 0, '0, 1));
            else
                for (int i = 0; i < ENTRIES; i++)
                    if (vld[i] && drt[i])
                        want_q.push_back(mk(i, 0, 0, 1, tags[i], i == lastd));
        end
        else if (q.req_type != REQ_RSVD)
        begin
            for (int i = 0; i < ENTRIES && s < 0; i++)
                if (vld[i] && tags[i] == q.sector) s = i;
            if (s >= 0) h = 1;
            else
            begin
                s = 0;
                for (int i = 1; i < ENTRIES; i++)
                    if (rank[i] > rank[s]) s = i;
                if (vld[s] && drt[s])
                begin
                    w = 1;
                    ws = tags[s];
                end
                tags[s] = q.sector;
                vld[s] = 1;
                drt[s] = 0;
            end
            if (q.req_type == REQ_WRITE) drt[s] = 1;
            r0 = rank[s];
            for (int i = 0; i < ENTRIES; i++)
                if (rank[i] < r0) rank[i]++;
            rank[s] = 0;
            want_q.push_back(mk(s, h, !h, w, ws, 1));
        end
    endtask

    assign pending = want_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_count = 0;
            want_q.delete();
            for (int i = 0; i < ENTRIES; i++)
            begin
                tags[i] = '0;
                vld[i] = 0;
                drt[i] = 0;
                rank[i] = i;
            end
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (want_q.size() == 0)
                    report($sformatf("unexpected result %h", out_data));
                else
                begin
                    rsp_t e;
                    e = want_q.pop_front();
                    if (out_data.slot !== e.slot)
                        report($sformatf("slot %0d want %0d", out_data.slot, e.slot));
                    if (out_data.hit !== e.hit)
                        report($sformatf("hit %b want %b", out_data.hit, e.hit));
                    if (out_data.fill_needed !== e.fill_needed)
                        report("fill_needed differs");
                    if (out_data.writeback_needed !== e.writeback_needed)
                        report("writeback_needed differs");
                    if (out_data.writeback_sector !== e.writeback_sector)
                        report($sformatf("writeback_sector %h want %h",
                                         out_data.writeback_sector, e.writeback_sector));
                    if (out_data.last !== e.last)
                        report("last differs");
                end
            end
            if (in_valid && !in_stall)
                predict_access(in_data);
        end
    end
endmodule

### verif/lru_writeback_sector_cache_ctrl_tb.sv
// Testbench top for the LRU write-back sector cache controller: drives requests
// in idling phases and gives the verdict. Depends on lwsc_pkg, lwsc_checker and the controller top.
`timescale 1ns / 1ps
module lru_writeback_sector_cache_ctrl_tb;
    import lwsc_pkg::*;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    req_t in_data;
    logic out_valid;
    logic out_stall;
    rsp_t out_data;
    int   fail_count;
    int   pending;
    int   send_idle_pct;  // percent of cycles the sender idles
    int   recv_stall_pct; // percent of cycles the receiver stalls
    bit   hold_off;       // long receiver hold-off in progress
    int   items_sent;

    lru_writeback_sector_cache_ctrl dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    lwsc_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Run limit: flushes, which walk every slot, dominate the run time.
    initial
    begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

    // Receiver: random stall each cycle at the phase's percentage, or a long hold-off when requested.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_off)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Small pool of sectors so hits, LRU evictions and dirty writebacks occur.
    logic [31:0] pool [16];

    function automatic logic [31:0] pick_sector();
        int r;
        r = $urandom_range(99);
        if (r < 75) return pool[$urandom_range(15)];
        if (r < 85) return $urandom_range(80) + 32'd100;
        return $urandom();
    endfunction

    function automatic logic [1:0] pick_type();
        int r;
        r = $urandom_range(99);
        if (r < 45) return REQ_READ;
        if (r < 90) return REQ_WRITE;
        if (r < 96) return REQ_FLUSH;
        return REQ_RSVD;
    endfunction

    // Offer one item, honoring sender idle percentage; hold until accepted.
    // Valid stays high after acceptance; the next call replaces or drops it,
    // or the end of the stimulus drops it.
    task automatic send_req(input logic [1:0] t, input logic [31:0] s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data.req_type <= t;
        in_data.sector <= s;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
    endtask

    task automatic run_phase(input int n, input int sp, input int rp);
        send_idle_pct = sp;
        recv_stall_pct = rp;
        for (int i = 0; i < n; i++)
            send_req(pick_type(), pick_sector());
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        items_sent = 0;
        for (int i = 0; i < 16; i++) pool[i] = $urandom();
        pool[0] = 32'h0;
        pool[1] = 32'hFFFF_FFFF;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: flush with nothing dirty, extremes, hits, write miss, reserved.
        send_req(REQ_FLUSH, 32'h0);
        send_req(REQ_READ, 32'h0);
        send_req(REQ_WRITE, 32'hFFFF_FFFF);
        send_req(REQ_READ, 32'hFFFF_FFFF);
        send_req(REQ_WRITE, 32'h0);
        send_req(REQ_RSVD, 32'h1234_5678);
        send_req(REQ_WRITE, 32'hAAAA_AAAA);
        send_req(REQ_READ, 32'h5555_5555);
        send_req(REQ_FLUSH, 32'hFFFF_FFFF);
        send_req(REQ_RSVD, 32'hFFFF_FFFF);
        send_req(REQ_READ, 32'h0);

        // Fill all 64 slots with dirty writes, then evict through LRU order.
        for (int i = 0; i < 66; i++)
            send_req(REQ_WRITE, 32'h1000 + i);
        send_req(REQ_FLUSH, 32'h0);
        for (int i = 0; i < 6; i++)
            send_req(REQ_READ, 32'h2000 + i);

        run_phase(70, 0, 0);
        run_phase(70, 58, 0);
        run_phase(70, 0, 58);
        run_phase(70, 8, 8);

        // Long receiver hold-off while the sender keeps offering items.
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            run_phase(20, 0, 0);
        join
        in_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
